@@ rtl/core/text_command_parser_assert.svh @@
// Assertion macros of the text command parser, included by tcp_scan.
`ifndef TEXT_COMMAND_PARSER_ASSERT_SVH
`define TEXT_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication, checked on clk, off while rst is high.
`define TCP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst is high.
`define TCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tcp_pkg.sv @@
// Types, constants and per-byte scan function of the text command parser.
package tcp_pkg;

  localparam int LaneLimit = 8;
  localparam int NumW      = $clog2(LaneLimit + 2);
  localparam int LaneW     = 4;
  localparam int KindW     = 2;
  localparam int PosW      = 4;

  typedef enum logic [3:0] {
    PH_SKIP   = 4'b0001,
    PH_MATCH  = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    KW_RESET  = 2'd0,
    KW_ARM    = 2'd1,
    KW_SET_LN = 2'd2,
    KW_LANES  = 2'd3
  } kw_t;

  typedef enum logic [KindW-1:0] {
    CMD_NONE  = 2'd0,
    CMD_RST   = 2'd1,
    CMD_ARM   = 2'd2,
    CMD_LANES = 2'd3
  } cmd_t;

  typedef struct packed {
    phase_t           phase;
    kw_t              choice;
    logic [PosW-1:0]  pos;
    logic [NumW-1:0]  num;
    logic             seen;
    cmd_t             decided;
  } scan_state_t;

  typedef struct packed {
    logic             valid;
    cmd_t             kind;
    logic [LaneW-1:0] lanes;
  } scan_result_t;

  localparam scan_state_t ScanIdle = '{
    phase:   PH_SKIP,
    choice:  KW_RESET,
    pos:     '0,
    num:     '0,
    seen:    1'b0,
    decided: CMD_NONE
  };

  function automatic logic [PosW-1:0] kw_len(kw_t kw);
    logic [PosW-1:0] len;
    unique case (kw)
      KW_RESET:  len = PosW'(5);
      KW_ARM:    len = PosW'(3);
      KW_SET_LN: len = PosW'(10);
      KW_LANES:  len = PosW'(6);
      default:   len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] kw_char(kw_t kw, logic [PosW-1:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (kw)
      KW_RESET: begin
        case (pos)
          4'd0: ch = "R";
          4'd1: ch = "E";
          4'd2: ch = "S";
          4'd3: ch = "E";
          4'd4: ch = "T";
          default: ch = 8'h00;
        endcase
      end
      KW_ARM: begin
        case (pos)
          4'd0: ch = "A";
          4'd1: ch = "R";
          4'd2: ch = "M";
          default: ch = 8'h00;
        endcase
      end
      KW_SET_LN: begin
        case (pos)
          4'd0: ch = "S";
          4'd1: ch = "E";
          4'd2: ch = "T";
          4'd3: ch = "_";
          4'd4: ch = "L";
          4'd5: ch = "A";
          4'd6: ch = "N";
          4'd7: ch = "E";
          4'd8: ch = "S";
          4'd9: ch = ":";
          default: ch = 8'h00;
        endcase
      end
      KW_LANES: begin
        case (pos)
          4'd0: ch = "L";
          4'd1: ch = "A";
          4'd2: ch = "N";
          4'd3: ch = "E";
          4'd4: ch = "S";
          4'd5: ch = ",";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic num_ok(scan_state_t s);
    return s.seen && (s.num >= NumW'(1)) && (s.num <= NumW'(LaneLimit));
  endfunction

  // One byte through the scanner; a zero byte ends scanning.
  function automatic scan_state_t take_byte(scan_state_t s, logic [7:0] b);
    scan_state_t       r;
    logic [7:0]        u;
    logic              ok;
    logic [PosW-1:0]   pos1;
    logic [NumW+3:0]   acc;
    logic [NumW+3:0]   v;
    r    = s;
    u    = (b >= "a" && b <= "z") ? b - 8'd32 : b;
    ok   = 1'b0;
    pos1 = s.pos + PosW'(1);
    acc  = {4'b0000, s.num};
    v    = (acc << 3) + (acc << 1) + (NumW + 4)'(b[3:0]);
    if (s.phase != PH_DONE && b == 8'h00) begin
      r.phase   = PH_DONE;
      r.decided = (s.phase == PH_DIGITS && num_ok(s)) ? CMD_LANES : CMD_NONE;
    end else begin
      unique case (s.phase)
        PH_SKIP: begin
          if (!(b == 8'h20 || (b >= 8'h09 && b <= 8'h0d))) begin
            r.pos   = PosW'(1);
            r.phase = PH_MATCH;
            if (u == "R") begin
              r.choice = KW_RESET;
            end else if (u == "A") begin
              r.choice = KW_ARM;
            end else if (u == "S") begin
              r.choice = KW_SET_LN;
            end else if (u == "L") begin
              r.choice = KW_LANES;
            end else begin
              r.pos     = s.pos;
              r.phase   = PH_DONE;
              r.decided = CMD_NONE;
            end
          end
        end
        PH_MATCH: begin
          if (s.pos < kw_len(s.choice)) begin
            ok = (u == kw_char(s.choice, s.pos));
            if (s.choice == KW_LANES && s.pos == PosW'(5) && b == 8'h20) begin
              ok = 1'b1;
            end
          end
          if (!ok) begin
            r.phase   = PH_DONE;
            r.decided = CMD_NONE;
          end else begin
            r.pos = pos1;
            if (pos1 == kw_len(s.choice)) begin
              unique case (s.choice)
                KW_RESET: begin
                  r.phase   = PH_DONE;
                  r.decided = CMD_RST;
                end
                KW_ARM: begin
                  r.phase   = PH_DONE;
                  r.decided = CMD_ARM;
                end
                default: begin
                  r.phase = PH_DIGITS;
                  r.num   = '0;
                  r.seen  = 1'b0;
                end
              endcase
            end
          end
        end
        PH_DIGITS: begin
          if (b >= "0" && b <= "9") begin
            r.seen = 1'b1;
            if (v > (NumW + 4)'(LaneLimit)) begin
              r.num = NumW'(LaneLimit + 1);
            end else begin
              r.num = v[NumW-1:0];
            end
          end else begin
            r.phase   = PH_DONE;
            r.decided = num_ok(s) ? CMD_LANES : CMD_NONE;
          end
        end
        default: r = s;
      endcase
    end
    return r;
  endfunction

endpackage

@@ rtl/core/tcp_scan.sv @@
// Scanner state registers and per-byte decode of the command text.
module tcp_scan (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           char_byte,
  input  logic                 last,
  output tcp_pkg::scan_result_t res
);
  import tcp_pkg::*;
  `include "text_command_parser_assert.svh"

  scan_state_t st;
  scan_state_t st_next;
  scan_state_t st_byte;
  scan_state_t st_end;

  always_comb begin
    st_byte = take_byte(st, char_byte);
    st_end  = take_byte(st_byte, 8'h00);
    if (fire) begin
      st_next = last ? ScanIdle : st_byte;
    end else begin
      st_next = st;
    end
  end

  always_comb begin
    res.valid = fire & last;
    res.kind  = st_end.decided;
    res.lanes = (st_end.decided == CMD_LANES) ? LaneW'(st_end.num) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ScanIdle;
    end else begin
      st <= st_next;
    end
  end

  `TCP_ASSERT_IMPLY(a_lanes_in_range,
    res.valid && res.kind == CMD_LANES,
    st_end.num >= NumW'(1) && st_end.num <= NumW'(LaneLimit),
    "set lanes issued with count out of range")
  `TCP_ASSERT_IMPLY(a_lanes_zero_otherwise,
    res.valid && res.kind != CMD_LANES, res.lanes == '0,
    "nonzero lane count on a non set lanes result")
  `TCP_ASSERT_NEXT(a_idle_after_end, fire && last,
    st.phase == PH_SKIP && st.num == '0 && !st.seen && st.decided == CMD_NONE,
    "scanner not back to idle after message end")
  `TCP_ASSERT_IMPLY(a_match_pos, st.phase == PH_MATCH,
    st.pos != '0 && st.pos < kw_len(st.choice),
    "keyword position outside keyword")
endmodule

@@ rtl/core/tcp_out_stage.sv @@
// Result register of the text command parser with upstream ready.
module tcp_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  tcp_pkg::scan_result_t res,
  output logic                  in_ready,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata
);
  import tcp_pkg::*;

  logic             valid;
  cmd_t             kind;
  logic [LaneW-1:0] lanes;

  assign in_ready      = !valid || m_axis_tready;
  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = {2'b00, lanes, kind};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res.valid) begin
      valid <= 1'b1;
    end else if (m_axis_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      kind  <= res.kind;
      lanes <= res.lanes;
    end
  end
endmodule

@@ rtl/core/text_command_parser.sv @@
// Top level of the streaming text command parser.
// Input: one message byte per transaction on s_axis; s_axis_tlast marks the
// last byte. Output: one result transaction on m_axis per message, given for
// the transaction that carries s_axis_tlast.
// Each byte is decoded in the cycle it is accepted and updates the scanner
// registers; the result is loaded into the output register on the last byte,
// so m_axis_tvalid rises in the cycle after that byte is accepted.
// Throughput: one byte per cycle, back to back, across message boundaries,
// while the receiver does not stall. s_axis_tready is high while the output
// register is empty or being drained; when the receiver stalls with a result
// waiting, input bytes are held off until that result is taken.
// Reset (rst, synchronous, active high) returns the scanner to leading
// whitespace skipping and empties the output register.
// Result: kind 0 none, 1 reset, 2 arm, 3 set lanes; lane count only for set
// lanes, else zero.
module text_command_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
  input  logic       s_axis_tlast,   // end_of_message
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [1:0] command_kind, [5:2] lane_count, [7:6] zero
);
  import tcp_pkg::*;

  logic         fire;
  scan_result_t res;

  assign fire = s_axis_tvalid && s_axis_tready;

  tcp_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .char_byte (s_axis_tdata),
    .last      (s_axis_tlast),
    .res       (res)
  );

  tcp_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .res           (res),
    .in_ready      (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );
endmodule

@@ sim/tcp_checker.sv @@
// Checker for the text command parser: predicts each message verdict and compares results.
module tcp_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,
  input  logic             s_axis_tlast,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [7:0]       m_axis_tdata,
  output int               fail_count,
  output int               verdicts_due,
  output logic [3:0][31:0] kind_tally
);
  import tcp_pkg::*;

  typedef struct {
    phase_t      ph;
    kw_t         word;
    int unsigned idx;
    int unsigned num;
    bit          got_digit;
    cmd_t        verdict;
  } parse_t;

  typedef struct {
    cmd_t       kind;
    logic [3:0] lanes;
  } verdict_t;

  parse_t   scan;
  verdict_t verdicts[$];

  function automatic parse_t fresh_scan();
    parse_t s;
    s.ph        = PH_SKIP;
    s.word      = KW_RESET;
    s.idx       = 0;
    s.num       = 0;
    s.got_digit = 1'b0;
    s.verdict   = CMD_NONE;
    return s;
  endfunction

  function automatic string word_text(kw_t w);
    case (w)
      KW_RESET:  return "RESET";
      KW_ARM:    return "ARM";
      KW_SET_LN: return $sformatf("SET_%s", "LANES:");
      default:   return "LANES,";
    endcase
  endfunction

  function automatic cmd_t judge_number(parse_t s);
    return (s.got_digit && s.num >= 1 && s.num <= LaneLimit) ? CMD_LANES : CMD_NONE;
  endfunction

  function automatic parse_t scan_byte(parse_t s, logic [7:0] b);
    parse_t     r;
    logic [7:0] up;
    string      txt;
    bit         hit;
    r  = s;
    up = (b >= 8'h61 && b <= 8'h7a) ? b - 8'd32 : b;
    if (s.ph == PH_DONE) begin
      r = s;
    end else if (b == 8'h00) begin
      r.verdict = (s.ph == PH_DIGITS) ? judge_number(s) : CMD_NONE;
      r.ph      = PH_DONE;
    end else if (s.ph == PH_SKIP) begin
      if (!(b == 8'h20 || (b >= 8'h09 && b <= 8'h0d))) begin
        r.idx = 1;
        r.ph  = PH_MATCH;
        case (up)
          "R": r.word = KW_RESET;
          "A": r.word = KW_ARM;
          "S": r.word = KW_SET_LN;
          "L": r.word = KW_LANES;
          default: begin
            r.ph      = PH_DONE;
            r.verdict = CMD_NONE;
          end
        endcase
      end
    end else if (s.ph == PH_MATCH) begin
      txt = word_text(s.word);
      hit = (s.idx < txt.len()) &&
            (up == txt[s.idx] || (s.word == KW_LANES && s.idx == 5 && b == 8'h20));
      if (!hit) begin
        r.ph      = PH_DONE;
        r.verdict = CMD_NONE;
      end else begin
        r.idx = s.idx + 1;
        if (r.idx == txt.len()) begin
          if (s.word == KW_RESET) begin
            r.ph      = PH_DONE;
            r.verdict = CMD_RST;
          end else if (s.word == KW_ARM) begin
            r.ph      = PH_DONE;
            r.verdict = CMD_ARM;
          end else begin
            r.ph        = PH_DIGITS;
            r.num       = 0;
            r.got_digit = 1'b0;
          end
        end
      end
    end else if (b >= "0" && b <= "9") begin
      r.num = s.num * 10 + int'(b - 8'h30);
      if (r.num > LaneLimit) begin
        r.num = LaneLimit + 1;
      end
      r.got_digit = 1'b1;
    end else begin
      r.verdict = judge_number(s);
      r.ph      = PH_DONE;
    end
    return r;
  endfunction

  task automatic report(string what);
    $display("%0t: mismatch: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    verdict_t want;
    parse_t   nxt;
    if (rst) begin
      scan = fresh_scan();
      verdicts.delete();
      fail_count = 0;
      kind_tally = '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts.size() == 0) begin
          report($sformatf("result 0x%02h with no message outstanding", m_axis_tdata));
        end else begin
          want = verdicts.pop_front();
          if (m_axis_tdata[1:0] !== want.kind) begin
            report($sformatf("command_kind %0d, expected %0d", m_axis_tdata[1:0], want.kind));
          end
          if (m_axis_tdata[5:2] !== want.lanes) begin
            report($sformatf("lane_count %0d, expected %0d", m_axis_tdata[5:2], want.lanes));
          end
          if (m_axis_tdata[7:6] !== 2'b00) begin
            report($sformatf("pad bits 0x%0h, expected 0", m_axis_tdata[7:6]));
          end
          kind_tally[want.kind] = kind_tally[want.kind] + 1;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        nxt = scan_byte(scan, s_axis_tdata);
        if (s_axis_tlast) begin
          nxt        = scan_byte(nxt, 8'h00);
          want.kind  = nxt.verdict;
          want.lanes = (nxt.verdict == CMD_LANES) ? 4'(nxt.num) : 4'h0;
          verdicts.push_back(want);
          nxt = fresh_scan();
        end
        scan = nxt;
      end
    end
    verdicts_due = verdicts.size();
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench top: drives command messages into the text command parser and gives the verdict.
module tb_top;
  import tcp_pkg::*;

  logic             clk           = 1'b0;
  logic             rst           = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = 8'h00;
  logic             s_axis_tlast  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b1;
  logic [7:0]       m_axis_tdata;
  int               fail_count;
  int               verdicts_due;
  logic [3:0][31:0] kind_tally;

  int         send_idle_pct = 0;
  int         stall_pct     = 0;
  int         bytes_sent    = 0;
  int         messages_sent = 0;
  logic [7:0] msg[$];

  text_command_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tcp_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .verdicts_due  (verdicts_due),
    .kind_tally    (kind_tally)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("text_command_parser regression: fail");
    $finish;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic add_text(string t);
    for (int i = 0; i < t.len(); i++) begin
      msg.push_back(t[i]);
    end
  endtask

  function automatic logic [7:0] any_case(logic [7:0] c);
    if (c >= "A" && c <= "Z" && $urandom_range(1)) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  // Entered and left at a falling edge; tvalid stays high between back-to-back bytes.
  task automatic send_message();
    for (int i = 0; i < msg.size(); i++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= msg[i];
      s_axis_tlast  <= (i == msg.size() - 1);
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      @(negedge clk);
      bytes_sent++;
    end
    msg.delete();
    messages_sent++;
  endtask

  task automatic build_random();
    int    pick;
    int    n;
    logic  [7:0] b;
    string word;
    pick = $urandom_range(99);
    repeat ($urandom_range(3)) begin
      b = 8'($urandom_range(13, 8));
      msg.push_back(b == 8'h08 ? 8'h20 : b);
    end
    if (pick < 80) begin
      case ($urandom_range(4))
        0:       word = "RESET";
        1:       word = "ARM";
        2:       word = $sformatf("SET_%s", "LANES:");
        3:       word = "LANES,";
        default: word = "LANES ";
      endcase
      n = word.len();
      // broken keywords: cut short, sometimes with a stray byte in place of the rest
      if (pick >= 65) begin
        n = $urandom_range(word.len() - 1, 1);
      end
      for (int i = 0; i < n; i++) begin
        msg.push_back(any_case(word[i]));
      end
      if (pick >= 65 && $urandom_range(1)) begin
        msg.push_back(8'($urandom_range(255)));
      end
      if (n == word.len() && word.len() >= 6) begin
        case ($urandom_range(3))
          0: add_text($sformatf("%0d", $urandom_range(LaneLimit + 2)));
          1: add_text($sformatf("00%0d", $urandom_range(LaneLimit)));
          2: repeat ($urandom_range(5, 1)) msg.push_back(8'h30 + 8'($urandom_range(9)));
          default: ;
        endcase
      end
      case ($urandom_range(3))
        0: ;
        1: begin
          msg.push_back(8'h00);
          repeat ($urandom_range(2)) msg.push_back(8'($urandom_range(255)));
        end
        2: add_text($sformatf("%c%0d", $urandom_range(8'h7a, 8'h3a), $urandom_range(9)));
        default: repeat ($urandom_range(3, 1)) msg.push_back(8'($urandom_range(255)));
      endcase
    end else begin
      repeat ($urandom_range(6, 1)) msg.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin : stimulus
    int phase_start;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    msg = '{8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h20};
    add_text("rEsEt");
    send_message();
    add_text("arm!x");
    send_message();
    add_text($sformatf("SET_%s%0d", "LANES:", LaneLimit));
    send_message();
    add_text("lanes,1");
    send_message();
    add_text("LANES 0");
    send_message();
    add_text($sformatf("LaNeS,%0d", LaneLimit + 1));
    send_message();
    add_text("set_");
    add_text("lanes:");
    send_message();
    add_text("LANES,0003x");
    send_message();
    add_text("LANES,99999");
    send_message();
    add_text("RES");
    msg.push_back(8'h00);
    add_text("ET");
    send_message();
    add_text("LANES,5");
    msg.push_back(8'h00);
    add_text("xyz");
    send_message();
    add_text("?RESET");
    send_message();
    msg.push_back(8'hff);
    send_message();
    msg.push_back(8'h00);
    send_message();
    add_text("ARM");
    send_message();
    add_text("LANES;4");
    send_message();
    add_text("lanes 12");
    send_message();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 460) begin
        build_random();
        send_message();
      end
      // hold off until every verdict of this phase has been taken
      s_axis_tvalid <= 1'b0;
      while (verdicts_due != 0) @(negedge clk);
    end

    repeat (20) @(negedge clk);
    $display("Sent %0d bytes in %0d messages: directed cases, then four flow-control phases.",
             bytes_sent, messages_sent);
    $display("Verdicts seen: none %0d, reset %0d, arm %0d, set lanes %0d.",
             kind_tally[CMD_NONE], kind_tally[CMD_RST], kind_tally[CMD_ARM],
             kind_tally[CMD_LANES]);
    if (fail_count == 0) begin
      $display("text_command_parser regression: pass");
    end else begin
      $display("text_command_parser regression: fail");
    end
    $finish;
  end

endmodule
